>>> design/sfla_pkg.sv
package sfla_pkg;

  // Allocator geometry
  localparam int SIZE_CLASSES = 64;
  localparam int STACK_DEPTH  = 16;
  localparam int CHUNK_LOG2   = 8;

  // Field widths
  localparam int COUNT_W = 32;
  localparam int ESIZE_W = 13;
  localparam int ADDR_W  = 46;
  localparam int ARENA_W = 47;

  // Derived widths
  localparam int PROD_W    = COUNT_W + ESIZE_W;
  localparam int CLS_W     = PROD_W + 1 - CHUNK_LOG2;
  localparam int CLS_AW    = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ENT_DEPTH = SIZE_CLASSES * STACK_DEPTH;
  localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

  localparam logic [ARENA_W-1:0] ARENA_RESET = ARENA_W'(1) << ADDR_W;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_REUSED  = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_FREED   = 3'd3,
    ST_NULL    = 3'd4,
    ST_DROPPED = 3'd5
  } status_t;

endpackage

>>> design/sfla_ram.sv
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with registered data held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/sfla_size.sv
module sfla_size
  import sfla_pkg::*;
(
  input  logic [COUNT_W-1:0] element_count,
  input  logic [ESIZE_W-1:0] element_size,
  output logic [CLS_W-1:0]   size_class
);

  logic [PROD_W-1:0] bytes;
  logic [PROD_W:0]   bytes_up;

  // Take the request size and round up to whole chunks
  assign bytes      = PROD_W'(element_count) * PROD_W'(element_size);
  assign bytes_up   = {1'b0, bytes} + (PROD_W + 1)'((1 << CHUNK_LOG2) - 1);
  assign size_class = bytes_up[PROD_W:CHUNK_LOG2];

endmodule

>>> design/segregated_free_list_allocator_core.sv
// Arena allocator with per-size-class LIFO free stacks. An allocate or free
// request enters as one transfer on the in_ channel and gives exactly one
// transfer on the out_ channel. For a plain allocate, a failed allocate and
// any free, the accepting cycle reads the class fill count from its memory and
// S_DEC decides and writes back; the result then enters the output register,
// or is parked in S_HOLD while that register is full. An allocate served from
// a free stack also passes through S_POP, as the stacked address is then read
// from the entry memory. Requests are handled one at a time; a new request is
// taken once the previous result has entered the output register, where it
// may still wait. Fill counts clear at reset through per-class valid bits, so
// no clearing pass is needed. arena_size may only be written while idle.
module segregated_free_list_allocator_core
  import sfla_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_wen,
  input  logic [ARENA_W-1:0] cfg_wdata,   // arena_size

  input  logic               in_tvalid,
  output logic               in_tready,
  // [31:0] element_count, [44:32] element_size, [90:45] block_address,
  // [91] address_present, [95:92] zero
  input  logic [95:0]        in_tdata,
  input  logic               in_tuser,    // [0] operation (0 allocate, 1 free)

  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,   // [45:0] result_address, [47:46] zero
  output logic [2:0]         out_tuser    // [2:0] status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_POP,
    S_HOLD
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   in_accept;
  logic [CLS_W-1:0]       size_class;

  // Request registers
  logic                   op_free_r, op_free_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic                   present_r, present_nxt;
  logic [CLS_W-1:0]       cls_r, cls_nxt;

  // Allocator state in flip-flops
  logic [ARENA_W-1:0]     arena_r, arena_nxt;
  logic [ARENA_W-1:0]     used_r, used_nxt;
  logic [SIZE_CLASSES-1:0] cnt_vld_r, cnt_vld_nxt;

  // Result staging
  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]      hold_addr_r, hold_addr_nxt;
  status_t                hold_status_r, hold_status_nxt;

  // Memory ports
  logic                   cnt_we;
  logic [CLS_AW-1:0]      cnt_waddr;
  logic [CNT_W-1:0]       cnt_wdata;
  logic [CNT_W-1:0]       cnt_rdata;
  logic                   ent_we;
  logic                   ent_re;
  logic [ENT_AW-1:0]      ent_waddr;
  logic [ENT_AW-1:0]      ent_raddr;
  logic [ADDR_W-1:0]      ent_rdata;

  // Decision terms
  logic [CLS_AW-1:0]      cls_idx;
  logic                   cls_ok;
  logic [CNT_W-1:0]       cnt;
  logic [ARENA_W:0]       bump_sum;
  logic                   no_space;
  logic [ENT_AW-1:0]      ent_base;
  logic                   out_free;
  logic                   fin;
  logic [ADDR_W-1:0]      fin_addr;
  status_t                fin_status;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  sfla_size u_size (
    .element_count (in_tdata[31:0]),
    .element_size  (in_tdata[44:32]),
    .size_class    (size_class)
  );

  // Fill count per class
  sfla_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SIZE_CLASSES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_accept),
    .raddr (size_class[CLS_AW-1:0]),
    .rdata (cnt_rdata)
  );

  // Stacked block addresses, one row of STACK_DEPTH per class
  sfla_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (addr_r),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Class lookup terms; an unwritten count reads as empty
  assign cls_idx  = cls_r[CLS_AW-1:0];
  assign cls_ok   = cls_r < CLS_W'(SIZE_CLASSES);
  assign cnt      = cnt_vld_r[cls_idx] ? cnt_rdata : '0;
  assign bump_sum = {1'b0, used_r} + (ARENA_W + 1)'({cls_r, {CHUNK_LOG2{1'b0}}});
  assign no_space = (bump_sum > {1'b0, arena_r}) || used_r[ARENA_W-1];
  assign ent_base = ENT_AW'(cls_idx * STACK_DEPTH);

  // Next-state and memory control
  always_comb begin
    state_nxt       = state_r;
    op_free_nxt     = op_free_r;
    addr_nxt        = addr_r;
    present_nxt     = present_r;
    cls_nxt         = cls_r;
    arena_nxt       = arena_r;
    used_nxt        = used_r;
    cnt_vld_nxt     = cnt_vld_r;
    out_valid_nxt   = out_valid_r;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    hold_addr_nxt   = hold_addr_r;
    hold_status_nxt = hold_status_r;
    cnt_we          = 1'b0;
    cnt_waddr       = cls_idx;
    cnt_wdata       = cnt;
    ent_we          = 1'b0;
    ent_re          = 1'b0;
    ent_waddr       = ent_base + ENT_AW'(cnt);
    ent_raddr       = ent_base + ENT_AW'(CNT_W'(cnt - 1'b1));
    fin             = 1'b0;
    fin_addr        = '0;
    fin_status      = ST_NEW;

    if (cfg_wen) begin
      arena_nxt = cfg_wdata;
    end

    // Drop the output once the transfer completes
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_free_nxt = in_tuser;
          addr_nxt    = in_tdata[90:45];
          present_nxt = in_tdata[91];
          cls_nxt     = size_class;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (!op_free_r) begin
          if (cls_ok && (cnt != '0)) begin
            // Pop: shrink the count and fetch the top entry
            cnt_we    = 1'b1;
            cnt_wdata = CNT_W'(cnt - 1'b1);
            ent_re    = 1'b1;
            state_nxt = S_POP;
          end else if (no_space) begin
            fin        = 1'b1;
            fin_status = ST_NOSPACE;
          end else begin
            fin        = 1'b1;
            fin_addr   = used_r[ADDR_W-1:0];
            fin_status = ST_NEW;
            used_nxt   = bump_sum[ARENA_W-1:0];
          end
        end else begin
          if (!present_r) begin
            fin        = 1'b1;
            fin_status = ST_NULL;
          end else if (!cls_ok || (cnt >= CNT_W'(STACK_DEPTH))) begin
            fin        = 1'b1;
            fin_status = ST_DROPPED;
          end else begin
            // Push the address and grow the count
            ent_we               = 1'b1;
            cnt_we               = 1'b1;
            cnt_wdata            = CNT_W'(cnt + 1'b1);
            cnt_vld_nxt[cls_idx] = 1'b1;
            fin                  = 1'b1;
            fin_status           = ST_FREED;
          end
        end
      end
      S_POP: begin
        fin        = 1'b1;
        fin_addr   = ent_rdata;
        fin_status = ST_REUSED;
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = hold_addr_r;
          out_status_nxt = hold_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = fin_addr;
        out_status_nxt = fin_status;
        state_nxt      = S_IDLE;
      end else begin
        hold_addr_nxt   = fin_addr;
        hold_status_nxt = fin_status;
        state_nxt       = S_HOLD;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    op_free_r     <= op_free_nxt;
    addr_r        <= addr_nxt;
    present_r     <= present_nxt;
    cls_r         <= cls_nxt;
    out_addr_r    <= out_addr_nxt;
    out_status_r  <= out_status_nxt;
    hold_addr_r   <= hold_addr_nxt;
    hold_status_r <= hold_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arena_r     <= ARENA_RESET;
      used_r      <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arena_r     <= arena_nxt;
      used_r      <= used_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_addr_r};
  assign out_tuser  = out_status_r;

  // The bump pointer never moves backwards
  a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> used_r >= $past(used_r))
    else $error("bump pointer moved backwards");

  // A stack count never passes its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> cnt_wdata <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A pop only ever comes from a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ent_re |-> (cnt != '0) && cls_ok && !op_free_r)
    else $error("pop from empty stack");

  // An accepted request is decided in the next cycle
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_DEC)
    else $error("accepted request not decided");

  // Entry memory is never written and read in the same cycle
  a_ent_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ent_we && ent_re))
    else $error("entry memory read and written together");

endmodule

>>> sim/alloc_result_checker.sv
// Watches the allocator's channels, keeps its own copy of the arena state,
// predicts the result of every request transfer and compares each result
// transfer against the oldest prediction.
module alloc_result_checker
  import sfla_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [ARENA_W-1:0] cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [95:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [47:0]        out_tdata,
  input  logic [2:0]         out_tuser,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output logic [ARENA_W-1:0] arena_used
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ADDR_LIMIT = (64'd1 << ADDR_W) - 64'd1;
  localparam int          CHUNK      = 1 << CHUNK_LOG2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } grant_t;

  grant_t            awaited_grants[$];
  grant_t            fresh;
  grant_t            got;
  grant_t            want;
  logic [ARENA_W-1:0] arena_limit;
  logic [ARENA_W-1:0] bump_offset;
  logic [ADDR_W-1:0]  class_stack [ENT_DEPTH];
  int unsigned        class_fill [SIZE_CLASSES];

  assign arena_used = bump_offset;

  // Work out the grant for one request and update the arena copy
  function automatic grant_t predict_grant(input logic              is_free,
                                           input logic [COUNT_W-1:0] count,
                                           input logic [ESIZE_W-1:0] esize,
                                           input logic [ADDR_W-1:0]  addr,
                                           input logic               present);
    logic [63:0] bytes;
    logic [63:0] cls;
    logic [63:0] rounded;
    int unsigned c;
    grant_t      g;
    bytes   = 64'(count) * 64'(esize);
    cls     = (bytes + 64'(CHUNK - 1)) >> CHUNK_LOG2;
    rounded = cls << CHUNK_LOG2;
    c       = int'(cls[CLS_AW-1:0]);
    g.addr  = '0;
    if (!is_free) begin
      if (cls < SIZE_CLASSES && class_fill[c] > 0) begin
        // pop the most recently freed block of this class
        class_fill[c] = class_fill[c] - 1;
        g.addr   = class_stack[c * STACK_DEPTH + class_fill[c]];
        g.status = ST_REUSED;
      end else if (64'(bump_offset) + rounded > 64'(arena_limit) ||
                   64'(bump_offset) > ADDR_LIMIT) begin
        g.status = ST_NOSPACE;
      end else begin
        g.addr      = bump_offset[ADDR_W-1:0];
        bump_offset = ARENA_W'(64'(bump_offset) + rounded);
        g.status    = ST_NEW;
      end
    end else if (!present) begin
      g.status = ST_NULL;
    end else if (cls >= SIZE_CLASSES || class_fill[c] >= STACK_DEPTH) begin
      g.status = ST_DROPPED;
    end else begin
      class_stack[c * STACK_DEPTH + class_fill[c]] = addr;
      class_fill[c] = class_fill[c] + 1;
      g.status = ST_FREED;
    end
    return g;
  endfunction

  // Predict on request transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      arena_limit = ARENA_RESET;
      bump_offset = '0;
      foreach (class_fill[i]) class_fill[i] = 0;
      awaited_grants.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_wen) arena_limit = cfg_wdata;
      if (in_tvalid && in_tready) begin
        fresh = predict_grant(in_tuser, in_tdata[31:0], in_tdata[44:32],
                              in_tdata[90:45], in_tdata[91]);
        awaited_grants = {awaited_grants, fresh};
      end
      if (out_tvalid && out_tready) begin
        got.addr   = out_tdata[ADDR_W-1:0];
        got.status = status_t'(out_tuser);
        if (awaited_grants.size() == 0) begin
          if (fail_count < 10)
            $display("%0t checker: result with none awaited, addr 0x%h status %0d",
                     $realtime, got.addr, out_tuser);
          fail_count++;
        end else begin
          want = awaited_grants.pop_front();
          checked++;
          if (got.addr != want.addr || got.status != want.status) begin
            if (fail_count < 10)
              $display("%0t checker: result %0d expected addr 0x%h %s, got 0x%h status %0d",
                       $realtime, checked, want.addr, want.status.name(), got.addr,
                       out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = awaited_grants.size();
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import sfla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 QUIET_LIMIT = 2000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [ADDR_W-1:0]  ADDR_MAX    = '1;

  logic               clk;
  logic               rst_n;
  logic               cfg_wen;
  logic [ARENA_W-1:0] cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [95:0]        in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [47:0]        out_tdata;
  logic [2:0]         out_tuser;

  int                 fail_count;
  int                 pending;
  int                 checked;
  logic [ARENA_W-1:0] arena_used;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          cfg_writes;
  int          quiet_cycles = 0;
  logic [63:0] remaining;
  logic [63:0] chunk_a;

  segregated_free_list_allocator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  alloc_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .arena_used (arena_used)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Offer one request, idling first at random; called and left at a falling edge
  task automatic push_request(input logic               is_free,
                              input logic [COUNT_W-1:0] count,
                              input logic [ESIZE_W-1:0] esize,
                              input logic [ADDR_W-1:0]  addr,
                              input logic               present);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_free;
    in_tdata  <= {4'b0, present, addr, esize, count};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Mostly sizes that land on a few busy classes, so stacks fill and empty
  task automatic push_random(input bit wide_allocs);
    logic               is_free;
    logic               present;
    logic [COUNT_W-1:0] count;
    logic [ESIZE_W-1:0] esize;
    logic [ADDR_W-1:0]  addr;
    int                 cls;
    int                 sh;
    int                 mode;
    is_free = ($urandom_range(0, 99) < 45);
    mode    = $urandom_range(0, 99);
    if (mode < 65) begin
      case ($urandom_range(0, 7))
        0: cls = 0;
        1: cls = 1;
        2: cls = 2;
        3: cls = 3;
        4: cls = 7;
        5: cls = SIZE_CLASSES - 1;
        6: cls = SIZE_CLASSES;
        default: cls = $urandom_range(0, SIZE_CLASSES - 1);
      endcase
      if (cls == 0) begin
        count = '0;
        esize = ESIZE_W'($urandom_range(1, 4096));
      end else begin
        sh    = $urandom_range(0, CHUNK_LOG2);
        esize = ESIZE_W'(1 << sh);
        count = COUNT_W'((((cls - 1) << CHUNK_LOG2) >> sh) +
                         $urandom_range(1, (1 << CHUNK_LOG2) >> sh));
      end
    end else if (mode < 90) begin
      esize = ESIZE_W'($urandom_range(1, 4096));
      count = COUNT_W'($urandom_range(0, 64));
    end else begin
      esize = ESIZE_W'($urandom_range(1, 4096));
      count = $urandom;
      // keep huge bumps away from the wide arena so it is not used up early
      if (!is_free && !wide_allocs) count = count >> 20;
    end
    addr = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(0, 1)) addr = ADDR_W'($urandom_range(0, 65535)) << CHUNK_LOG2;
    present = is_free ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
    push_request(is_free, count, esize, addr, present);
  endtask

  task automatic run_random(input int n, input bit wide_allocs);
    repeat (n) push_random(wide_allocs);
  endtask

  // Drop valid and hold until every awaited result has been transferred
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_arena(input logic [ARENA_W-1:0] value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    cfg_writes     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero-byte, extremes, null free, pops, oversize and full stack
    push_request(1'b0, '0, 13'd1, '0, 1'b0);
    push_request(1'b0, 32'd1, 13'd1, '0, 1'b1);
    push_request(1'b0, COUNT_MAX, 13'd4096, ADDR_MAX, 1'b1);
    push_request(1'b1, 32'd1, 13'd256, ADDR_MAX, 1'b0);
    push_request(1'b1, 32'd1, 13'd256, ADDR_MAX, 1'b1);
    push_request(1'b0, 32'd256, 13'd1, '0, 1'b0);
    push_request(1'b1, '0, 13'd4096, 46'h123, 1'b1);
    push_request(1'b0, '0, 13'd4096, '0, 1'b1);
    push_request(1'b1, COUNT_MAX, 13'd4096, '0, 1'b1);
    push_request(1'b1, 32'd16129, 13'd1, 46'h2A_5555_AAAA, 1'b1);
    push_request(1'b1, 32'd16128, 13'd1, 46'h15_AAAA_5555, 1'b1);
    for (int i = 0; i <= STACK_DEPTH; i++)
      push_request(1'b1, 32'd2, 13'd256, ADDR_W'(i) << 12, 1'b1);
    push_request(1'b0, 32'd512, 13'd1, '0, 1'b1);

    // Wide arena, no idling
    set_arena(ARENA_RESET);
    run_random(150, 1'b0);

    // Arena lowered to nothing: of the allocates, only pops succeed
    set_arena('0);
    send_idle_pct = 88;
    run_random(100, 1'b1);

    // A little headroom above the bump pointer, so space runs out
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    wait_idle();
    set_arena(arena_used + ARENA_W'($urandom_range(0, 1 << 20)));
    run_random(200, 1'b1);

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    wait_idle();
    set_arena(arena_used + ARENA_W'(1 << 22) + ARENA_W'($urandom_range(0, 1 << 22)));
    run_random(150, 1'b1);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_arena(ARENA_RESET);
    run_random(150, 1'b0);

    // Bump exactly to the end of the 2^46-byte arena with oversize requests
    set_arena(ARENA_RESET);
    remaining = 64'(ARENA_RESET) - 64'(arena_used);
    while (remaining > (64'd1 << 43)) begin
      push_request(1'b0, 32'd1 << 30, 13'd4096, '0, 1'b1);
      remaining -= 64'd1 << 42;
    end
    chunk_a = (remaining & 64'hF_FFFF) + (64'd1 << 20);
    push_request(1'b0, COUNT_W'(chunk_a >> 8), 13'd256, '0, 1'b1);
    remaining -= chunk_a;
    push_request(1'b0, COUNT_W'(remaining >> 12), 13'd4096, '0, 1'b1);
    // zero-byte requests drain class 0, then hit the address limit
    repeat (STACK_DEPTH + 1)
      push_request(1'b0, '0, ESIZE_W'($urandom_range(1, 4096)), '0, 1'b1);
    push_request(1'b1, 32'd1, 13'd256, 46'h3FF00, 1'b1);
    push_request(1'b0, 32'd1, 13'd256, '0, 1'b1);
    push_request(1'b0, 32'd1, 13'd256, '0, 1'b1);
    push_request(1'b0, 32'h10000, 13'd1, '0, 1'b1);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("tb_top: %0d requests across four idle patterns, lowered and exhausted arenas",
             items_sent);
    $display("tb_top: %0d results checked, %0d arena_size writes, %0d failures",
             checked, cfg_writes, fail_count + pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
